### rtl/pgw_pkg.sv
`default_nettype none

package pgw_pkg;

	localparam int unsigned VaddrW  = 48;
	localparam int unsigned DataW   = 64;
	localparam int unsigned IdxW    = 9;
	localparam int unsigned PageW   = 12;
	localparam int unsigned LevelW  = 2;
	localparam int unsigned EntryW  = 3;

	localparam int unsigned Shift0  = 39;
	localparam int unsigned Shift1  = 30;
	localparam int unsigned Shift2  = 21;
	localparam int unsigned Shift3  = 12;

	// input beat kinds
	localparam logic KIND_REQ = 1'b0;
	localparam logic KIND_RSP = 1'b1;

	// result beat kinds
	localparam logic RES_READ = 1'b0;
	localparam logic RES_DONE = 1'b1;

	localparam logic [LevelW-1:0] LEVEL_TOP  = 2'd0;
	localparam logic [LevelW-1:0] LEVEL_LEAF = 2'd3;

	typedef struct packed {
		logic              active;
		logic [LevelW-1:0] level;
		logic [VaddrW-1:0] vaddr;
	} walk_state_t;

	typedef struct packed {
		logic              kind;
		logic [DataW-1:0]  read_addr;
		logic              found;
		logic [LevelW-1:0] fault_level;
		logic [DataW-1:0]  leaf_entry;
		logic [DataW-1:0]  phys_addr;
	} walk_result_t;

	// table index of a virtual address at a given level
	function automatic logic [IdxW-1:0] pgw_index(input logic [VaddrW-1:0] va,
			input logic [LevelW-1:0] lvl);
		logic [IdxW-1:0] idx;
		case (lvl)
			2'd0:    idx = va[Shift0 +: IdxW];
			2'd1:    idx = va[Shift1 +: IdxW];
			2'd2:    idx = va[Shift2 +: IdxW];
			default: idx = va[Shift3 +: IdxW];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/pgw_step.sv
`default_nettype none

module pgw_step import pgw_pkg::*; (
	input  wire walk_state_t              st,
	input  wire logic                     kind,
	input  wire logic [DataW-1:0]         root_addr,
	input  wire logic [VaddrW-1:0]        virt_addr,
	input  wire logic [DataW-1:0]         read_data,
	input  wire logic [DataW-1:0]         table_offset,
	output walk_state_t                   nxt,
	output logic                          res_valid,
	output walk_result_t                  res
);

	logic [DataW-1:0]  next_base;
	logic [LevelW-1:0] next_level;

	// one wide add per beat: entry plus configured offset
	assign next_base  = read_data + table_offset;
	assign next_level = st.level + 2'd1;

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		if (kind == KIND_REQ) begin
			if (!st.active) begin
				nxt.active    = 1'b1;
				nxt.level     = LEVEL_TOP;
				nxt.vaddr     = virt_addr;
				res_valid     = 1'b1;
				res.kind      = RES_READ;
				res.read_addr = {root_addr[DataW-1:PageW],
					pgw_index(virt_addr, LEVEL_TOP), {EntryW{1'b0}}};
			end
		end else if (st.active) begin
			res_valid = 1'b1;
			if (!read_data[0]) begin
				// not present: fault at this level
				nxt.active      = 1'b0;
				res.kind        = RES_DONE;
				res.fault_level = st.level;
			end else if (st.level != LEVEL_LEAF) begin
				nxt.level     = next_level;
				res.kind      = RES_READ;
				res.read_addr = {next_base[DataW-1:PageW],
					pgw_index(st.vaddr, next_level), {EntryW{1'b0}}};
			end else begin
				nxt.active     = 1'b0;
				res.kind       = RES_DONE;
				res.found      = 1'b1;
				res.leaf_entry = read_data;
				res.phys_addr  = {read_data[DataW-1:PageW], st.vaddr[PageW-1:0]};
			end
		end
	end

endmodule

`default_nettype wire

### rtl/four_level_page_table_walker.sv
// Four-level page table walker, 9 index bits per level. One input channel
// carries both translate requests (kind 0) and memory read responses (kind 1);
// one output channel carries read requests (result_kind 0) and walk-finished
// beats (result_kind 1). A request starts a walk and yields a read of the top
// table entry; each present response yields the read for the next level, where
// the next table base is entry plus table_offset with the low 12 bits cleared.
// A clear present bit ends the walk with fault_level; the fourth present entry
// ends it with found, the leaf entry and the physical address. A request while
// a walk runs and a response while idle are dropped without a result beat.
// Rate: one input beat per cycle, sustained while the output is not stalled. A
// beat is held in the input register, the step logic (a single 64-bit add plus
// index muxing) runs on it, and the result lands in the output register, which
// drives out_valid. The output register lets the next beat enter while a result
// still waits; a stalled output holds the pipe only when the beat in the input
// register would produce a result. The user must write table_offset through
// cfg_wr_en/cfg_wr_data only while the walker is idle; the block itself does
// not enforce this.
`default_nettype none

module four_level_page_table_walker import pgw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_wr_en,
	input  wire logic [DataW-1:0]  cfg_wr_data,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic [DataW-1:0]  root_addr,
	input  wire logic [VaddrW-1:0] virt_addr,
	input  wire logic [DataW-1:0]  read_data,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   result_kind,
	output logic [DataW-1:0]       read_addr,
	output logic                   found,
	output logic [LevelW-1:0]      fault_level,
	output logic [DataW-1:0]       leaf_entry,
	output logic [DataW-1:0]       phys_addr
);

	// configuration register
	logic [DataW-1:0] table_offset_q;

	// walk state
	walk_state_t st_q;
	walk_state_t st_nxt;

	// input register stage
	logic              valid_s1;
	logic              kind_s1;
	logic [DataW-1:0]  root_addr_s1;
	logic [VaddrW-1:0] virt_addr_s1;
	logic [DataW-1:0]  read_data_s1;

	// output register stage
	logic              valid_s2;
	walk_result_t      res_s2;

	logic              step_res_valid;
	walk_result_t      step_res;
	logic              adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_offset_q <= '0;
		end else if (cfg_wr_en) begin
			table_offset_q <= cfg_wr_data;
		end
	end

	pgw_step u_step (
		.st           (st_q),
		.kind         (kind_s1),
		.root_addr    (root_addr_s1),
		.virt_addr    (virt_addr_s1),
		.read_data    (read_data_s1),
		.table_offset (table_offset_q),
		.nxt          (st_nxt),
		.res_valid    (step_res_valid),
		.res          (step_res)
	);

	// a dropped beat never waits on the output side
	assign adv_s1   = valid_s1 && (!step_res_valid || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1      <= kind;
			root_addr_s1 <= root_addr;
			virt_addr_s1 <= virt_addr;
			read_data_s1 <= read_data;
		end
	end

	// walk state advances in beat order as each beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && step_res_valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_res_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid   = valid_s2;
	assign result_kind = res_s2.kind;
	assign read_addr   = res_s2.read_addr;
	assign found       = res_s2.found;
	assign fault_level = res_s2.fault_level;
	assign leaf_entry  = res_s2.leaf_entry;
	assign phys_addr   = res_s2.phys_addr;

	// a finished walk leaves the walker idle
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_res_valid && step_res.kind == RES_DONE) |=> !st_q.active)
		else $error("walker still active after finish beat");

	// a read request leaves the walker active
	a_read_stays_active: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_res_valid && step_res.kind == RES_READ) |=> st_q.active)
		else $error("walker idle after issuing a read");

	// read addresses are entry aligned
	a_read_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == RES_READ) |-> res_s2.read_addr[EntryW-1:0] == '0)
		else $error("misaligned read address");

	// a found walk reports no fault level
	a_found_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.found) |-> (res_s2.kind == RES_DONE && res_s2.fault_level == '0))
		else $error("found beat carries fault level");

	// output register never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
